// ===== rtl/mealy_equivalence_checker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Mealy equivalence checker
// Shorthand for clocked implication properties used by the checker module.
// ----------------------------------------------------------------------------
`ifndef MEALY_EQUIVALENCE_CHECKER_TOP_MACROS_SVH
`define MEALY_EQUIVALENCE_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MEC_ASSERT_SAME(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MEC_ASSERT_NEXT(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mec_pkg.sv =====
// ----------------------------------------------------------------------------
// mec_pkg
// Shared constants and command codes of the Mealy equivalence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  // Width of the state fields on the ports and of the widest state number.
  localparam int FIELD_BITS     = 4;
  localparam int STATE_MAX_BITS = 8;

  // State widths of the two machines (1 to 8 bits each).
  localparam int STATE_BITS_A = 4;
  localparam int STATE_BITS_B = 4;

  localparam int PAIR_BITS = STATE_BITS_A + STATE_BITS_B;
  localparam int NPAIRS    = 1 << PAIR_BITS;
  localparam int TAB_A_DEPTH = 2 << STATE_BITS_A;
  localparam int TAB_B_DEPTH = 2 << STATE_BITS_B;

  // Command codes carried on func.
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_CHECK  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_START_A = 1'b0;
  localparam logic CFG_START_B = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/mealy_equivalence_checker_top.sv =====
// ----------------------------------------------------------------------------
// mealy_equivalence_checker_top
// Loads two Mealy machine tables and checks them for equivalence by a
// depth-first walk of their product automaton.
// ----------------------------------------------------------------------------
// Results: a load beat writes its table entry and yields no result. A check
// beat sets done at the end of its walk: a pass clears the visited bitmap,
// each popped pair (at most 256) then passes POP, FETCH, CMP0, PUSH0, CMP1 and
// PUSH1, and a final empty pop ends the walk. A mismatch ends the walk early.
// Throughput: one load per cycle while idle; a check holds busy for its whole walk.
// Reset (rst, synchronous, active high) returns to idle and clears the start
// registers; the results strobe cannot be stalled by the receiver.
`default_nettype none

module mealy_equivalence_checker_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     func,
  input  wire logic [mec_pkg::FIELD_BITS-1:0] state_index,
  input  wire logic                           input_symbol,
  input  wire logic [mec_pkg::FIELD_BITS-1:0] next_state,
  input  wire logic                           output_symbol,
  // configuration write port
  input  wire logic                           cfg_write,
  input  wire logic                           cfg_index,
  input  wire logic [mec_pkg::FIELD_BITS-1:0] cfg_data,
  // result channel
  output logic                                done,
  output logic                                equivalent
);

  import mec_pkg::*;

  // Sequencer states. A check first clears the visited bitmap, one entry per
  // cycle, and marks the start pair on the way. Each popped pair then visits
  // POP, FETCH, CMP0, PUSH0, CMP1 and PUSH1: POP reads the stack, FETCH reads
  // both tables for input 0, CMP0 compares input 0, reads input 1 and looks
  // up the successor in the bitmap, PUSH0 pushes it if it is new. CMP1 and
  // PUSH1 do the same for input 1.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_CMP0  = 3'd4;
  localparam logic [2:0] S_PUSH0 = 3'd5;
  localparam logic [2:0] S_CMP1  = 3'd6;
  localparam logic [2:0] S_PUSH1 = 3'd7;

  localparam int PAD_BITS = STATE_MAX_BITS - FIELD_BITS;

  logic [2:0] state;
  logic [2:0] state_next;

  // Start pair registers, already masked to each machine's state width.
  logic [STATE_BITS_A-1:0] start_a;
  logic [STATE_BITS_B-1:0] start_b;

  // Table memories: each entry holds {next state, output bit}.
  logic [STATE_BITS_A:0] tab_a [TAB_A_DEPTH];
  logic [STATE_BITS_B:0] tab_b [TAB_B_DEPTH];
  logic [STATE_BITS_A:0] rd_a;
  logic [STATE_BITS_B:0] rd_b;

  // Pair stack memory, its registered read data and the depth counter.
  logic [PAIR_BITS-1:0] stack [NPAIRS];
  logic [PAIR_BITS-1:0] stack_q;
  logic [PAIR_BITS:0]   sp;
  logic [PAIR_BITS:0]   sp_dec;

  // Visited bitmap over state pairs, cleared by a pass at each check, with
  // its registered read data and the clearing address.
  logic                 visited [NPAIRS];
  logic                 vis_q;
  logic [PAIR_BITS-1:0] clr_cnt;
  logic [PAIR_BITS-1:0] succ_q;

  // Port fields widened to the largest state width, then masked per machine.
  logic [STATE_MAX_BITS-1:0] idx_ext;
  logic [STATE_MAX_BITS-1:0] nxt_ext;
  logic [STATE_MAX_BITS-1:0] cfg_ext;

  logic                 accept;
  logic                 load_a;
  logic                 load_b;
  logic                 check_go;
  logic [PAIR_BITS-1:0] start_pair;
  logic [PAIR_BITS-1:0] succ_pair;
  logic                 out_differ;
  logic                 push_ok;
  logic                 in_cmp;
  logic                 in_push;
  logic                 rd_sym;
  logic                 clr_last;
  logic [STATE_BITS_A:0] raddr_a;
  logic [STATE_BITS_B:0] raddr_b;
  logic [STATE_BITS_A:0] waddr_a;
  logic [STATE_BITS_B:0] waddr_b;

  assign idx_ext = {{PAD_BITS{1'b0}}, state_index};
  assign nxt_ext = {{PAD_BITS{1'b0}}, next_state};
  assign cfg_ext = {{PAD_BITS{1'b0}}, cfg_data};

  // A beat is taken whenever the sequencer is idle.
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign load_a   = accept && (func == FUNC_LOAD_A);
  assign load_b   = accept && (func == FUNC_LOAD_B);
  assign check_go = accept && (func == FUNC_CHECK);

  assign start_pair = {start_a, start_b};
  assign waddr_a    = {idx_ext[STATE_BITS_A-1:0], input_symbol};
  assign waddr_b    = {idx_ext[STATE_BITS_B-1:0], input_symbol};

  // The input symbol bit of the table address is 1 while CMP0 and PUSH0
  // fetch the second entry of the current pair, so that the entry is still
  // on the read data when CMP1 compares it.
  assign rd_sym  = (state == S_CMP0) || (state == S_PUSH0);
  assign raddr_a = {stack_q[PAIR_BITS-1:STATE_BITS_B], rd_sym};
  assign raddr_b = {stack_q[STATE_BITS_B-1:0], rd_sym};

  // Compare stage: the output bits of the fetched entries and the pair of
  // successor states that may have to be pushed.
  assign in_cmp     = (state == S_CMP0) || (state == S_CMP1);
  assign in_push    = (state == S_PUSH0) || (state == S_PUSH1);
  assign out_differ = (rd_a[0] != rd_b[0]);
  assign succ_pair  = {rd_a[STATE_BITS_A:1], rd_b[STATE_BITS_B:1]};
  assign push_ok    = in_push && !vis_q;
  assign sp_dec     = sp - 1'b1;
  assign clr_last   = &clr_cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (check_go) state_next = S_CLEAR;
      S_CLEAR: if (clr_last) state_next = S_POP;
      S_POP:   state_next = (sp == '0) ? S_IDLE : S_FETCH;
      S_FETCH: state_next = S_CMP0;
      S_CMP0:  state_next = out_differ ? S_IDLE : S_PUSH0;
      S_PUSH0: state_next = S_CMP1;
      S_CMP1:  state_next = out_differ ? S_IDLE : S_PUSH1;
      S_PUSH1: state_next = S_POP;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_a    <= '0;
      start_b    <= '0;
      sp         <= '0;
      clr_cnt    <= '0;
      done       <= 1'b0;
      equivalent <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;

      if (cfg_write) begin
        if (cfg_index == CFG_START_A) begin
          start_a <= cfg_ext[STATE_BITS_A-1:0];
        end else begin
          start_b <= cfg_ext[STATE_BITS_B-1:0];
        end
      end

      // A new check pushes the start pair at once; the clearing pass that
      // follows marks it as visited.
      if (check_go) begin
        sp      <= {{PAIR_BITS{1'b0}}, 1'b1};
        clr_cnt <= '0;
      end

      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end

      if (state == S_POP) begin
        if (sp == '0) begin
          // Stack ran dry without a mismatch: the machines agree.
          done       <= 1'b1;
          equivalent <= 1'b1;
        end else begin
          sp <= sp_dec;
        end
      end

      if (in_cmp) begin
        if (out_differ) begin
          done       <= 1'b1;
          equivalent <= 1'b0;
        end else begin
          succ_q <= succ_pair;
        end
      end

      if (push_ok) begin
        sp <= sp + 1'b1;
      end
    end
  end

  // Table memories: written by load beats, read once per cycle during a walk.
  always_ff @(posedge clk) begin
    if (load_a) begin
      tab_a[waddr_a] <= {nxt_ext[STATE_BITS_A-1:0], output_symbol};
    end
    if (load_b) begin
      tab_b[waddr_b] <= {nxt_ext[STATE_BITS_B-1:0], output_symbol};
    end
    rd_a <= tab_a[raddr_a];
    rd_b <= tab_b[raddr_b];
  end

  // Visited bitmap: one write (clear or mark) and one lookup per cycle.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      visited[clr_cnt] <= (clr_cnt == start_pair);
    end else if (push_ok) begin
      visited[succ_q] <= 1'b1;
    end
    vis_q <= visited[succ_pair];
  end

  // Pair stack: one write (start or push) or one read (pop) per cycle.
  always_ff @(posedge clk) begin
    if (check_go) begin
      stack[0] <= start_pair;
    end else if (push_ok) begin
      stack[sp[PAIR_BITS-1:0]] <= succ_q;
    end
    if (state == S_POP) begin
      stack_q <= stack[sp_dec[PAIR_BITS-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mec_checker.sv =====
// ----------------------------------------------------------------------------
// mec_checker
// Port-level assertions on the command and result beats of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mealy_equivalence_checker_top_macros.svh"

module mec_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] func,
  input wire logic       done
);

  import mec_pkg::*;

  logic check_beat;
  logic other_beat;

  assign check_beat = start && !busy && (func == FUNC_CHECK);
  assign other_beat = start && !busy && (func != FUNC_CHECK);

  // A result beat always lands while the block is idle again.
  `MEC_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result beat while busy")

  // A check beat makes the block busy on the next cycle.
  `MEC_ASSERT_NEXT(a_check_busy, clk, rst, check_beat, busy, "check beat did not start a walk")

  // Load and unused beats leave the block idle and produce no result.
  `MEC_ASSERT_NEXT(a_load_quiet, clk, rst, other_beat, !busy && !done, "non-check beat moved")

  // A walk starts with the clearing pass, so result beats never come back to back.
  `MEC_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "two result beats in a row")

endmodule

bind mealy_equivalence_checker_top mec_checker u_mec_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);

`default_nettype wire
